[sv/mld_pkg.sv]
package mld_pkg;

  // Largest command payload that is matched rather than drained
  localparam int unsigned MaxPayload = 256;

  // Parse phases
  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhCmd   = 2'd1;
  localparam logic [1:0] PhDrain = 2'd2;

  // Header layout
  localparam logic [2:0] HdrLast = 3'd7;

  // Result event codes
  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvStart    = 3'd1,
    EvLegacy   = 3'd2,
    EvBadMagic = 3'd3,
    EvOversize = 3'd4,
    EvDone     = 3'd5,
    EvDrained  = 3'd6
  } event_e;

  localparam logic [7:0] LegacyMagic [4] = '{8'hAA, 8'hBB, 8'hCC, 8'hDD};
  localparam logic [7:0] CmdMagic    [4] = '{8'hAA, 8'hBB, 8'hCC, 8'hEE};

  // Quoted words: "ota" and "reboot"
  localparam logic [7:0] Quote = 8'h22;
  localparam logic [7:0] OtaWord    [5] = '{8'h22, 8'h6F, 8'h74, 8'h61, 8'h22};
  localparam logic [7:0] RebootWord [8] = '{8'h22, 8'h72, 8'h65, 8'h62,
                                            8'h6F, 8'h6F, 8'h74, 8'h22};
  localparam logic [2:0] OtaLastIdx    = 3'd4;
  localparam logic [2:0] RebootLastIdx = 3'd7;

  // One stream item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  // One result item
  typedef struct packed {
    event_e      event_res;
    logic        ota_request;
    logic        reboot_request;
    logic [31:0] bad_magic_total;
    logic [31:0] legacy_frame_total;
  } result_t;

endpackage

[sv/mld_in_stage.sv]
module mld_in_stage import mld_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  kind_i,
  input  logic  [7:0] data_byte_i,
  input  logic  advance_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  // Input register frees up whenever the parser consumes its content
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q.kind      <= kind_i;
      item_q.data_byte <= data_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[sv/mld_parser.sv]
module mld_parser import mld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  input  logic    advance_i,
  output result_t result_o
);

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  hdr_store_q [7];
  logic [31:0] len_q, len_d;
  logic [31:0] pay_cnt_q, pay_cnt_d;
  logic [2:0]  ota_prog_q, ota_prog_d;
  logic [2:0]  rbt_prog_q, rbt_prog_d;
  logic        ota_seen_q, ota_seen_d;
  logic        rbt_seen_q, rbt_seen_d;
  logic        zero_seen_q, zero_seen_d;
  logic [31:0] bad_cnt_q, bad_cnt_d;
  logic [31:0] leg_cnt_q, leg_cnt_d;

  logic        fire;
  logic        hdr_wr;
  logic [7:0]  c;
  logic [31:0] pay_inc;
  logic [31:0] hdr_len;
  logic        is_legacy, is_cmd;
  logic        ota_hit, rbt_hit;
  logic        ota_match, rbt_match;
  event_e      ev;
  logic        ota_req, rbt_req;

  assign fire    = item_valid_i && advance_i;
  assign c       = item_i.data_byte;
  assign pay_inc = pay_cnt_q + 32'd1;
  assign hdr_len = {c, hdr_store_q[6], hdr_store_q[5], hdr_store_q[4]};

  assign is_legacy = (hdr_store_q[0] == LegacyMagic[0]) && (hdr_store_q[1] == LegacyMagic[1]) &&
                     (hdr_store_q[2] == LegacyMagic[2]) && (hdr_store_q[3] == LegacyMagic[3]);
  assign is_cmd    = (hdr_store_q[0] == CmdMagic[0]) && (hdr_store_q[1] == CmdMagic[1]) &&
                     (hdr_store_q[2] == CmdMagic[2]) && (hdr_store_q[3] == CmdMagic[3]);

  // Word matchers: next expected character compared against the byte
  assign ota_match = (OtaWord[ota_prog_q] == c);
  assign rbt_match = (RebootWord[rbt_prog_q] == c);
  assign ota_hit   = ota_match && (ota_prog_q == OtaLastIdx);
  assign rbt_hit   = rbt_match && (rbt_prog_q == RebootLastIdx);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_d       = len_q;
    pay_cnt_d   = pay_cnt_q;
    ota_prog_d  = ota_prog_q;
    rbt_prog_d  = rbt_prog_q;
    ota_seen_d  = ota_seen_q;
    rbt_seen_d  = rbt_seen_q;
    zero_seen_d = zero_seen_q;
    bad_cnt_d   = bad_cnt_q;
    leg_cnt_d   = leg_cnt_q;
    hdr_wr      = 1'b0;
    ev          = EvNone;
    ota_req     = 1'b0;
    rbt_req     = 1'b0;

    if (item_i.kind) begin
      // link restart
      phase_d   = PhHunt;
      hdr_cnt_d = '0;
      pay_cnt_d = '0;
    end else if (phase_q == PhCmd || phase_q == PhDrain) begin
      pay_cnt_d = pay_inc;
      if (phase_q == PhCmd && !zero_seen_q) begin
        if (c == 8'h00) begin
          zero_seen_d = 1'b1;
        end else begin
          if (!ota_seen_q) begin
            if (ota_hit) begin
              ota_seen_d = 1'b1;
              ota_prog_d = '0;
            end else if (ota_match) begin
              ota_prog_d = ota_prog_q + 3'd1;
            end else begin
              ota_prog_d = (c == Quote) ? 3'd1 : 3'd0;
            end
          end
          if (!rbt_seen_q) begin
            if (rbt_hit) begin
              rbt_seen_d = 1'b1;
              rbt_prog_d = '0;
            end else if (rbt_match) begin
              rbt_prog_d = rbt_prog_q + 3'd1;
            end else begin
              rbt_prog_d = (c == Quote) ? 3'd1 : 3'd0;
            end
          end
        end
      end
      if (pay_inc >= len_q) begin
        if (phase_q == PhCmd) begin
          ev      = EvDone;
          ota_req = ota_seen_d;
          rbt_req = rbt_seen_d && !ota_seen_d;
        end else begin
          ev = EvDrained;
        end
        phase_d   = PhHunt;
        hdr_cnt_d = '0;
        pay_cnt_d = '0;
      end
    end else if (hdr_cnt_q != HdrLast) begin
      // header collection
      hdr_wr    = 1'b1;
      hdr_cnt_d = hdr_cnt_q + 3'd1;
    end else begin
      // last header byte: classify
      len_d     = hdr_len;
      hdr_cnt_d = '0;
      pay_cnt_d = '0;
      if (is_legacy) begin
        leg_cnt_d = leg_cnt_q + 32'd1;
        ev        = EvLegacy;
        phase_d   = PhDrain;
      end else if (is_cmd) begin
        if (hdr_len <= 32'(MaxPayload)) begin
          ev          = EvStart;
          phase_d     = PhCmd;
          ota_prog_d  = '0;
          rbt_prog_d  = '0;
          ota_seen_d  = 1'b0;
          rbt_seen_d  = 1'b0;
          zero_seen_d = 1'b0;
        end else begin
          ev      = EvOversize;
          phase_d = PhDrain;
        end
      end else begin
        bad_cnt_d = bad_cnt_q + 32'd1;
        ev        = EvBadMagic;
        phase_d   = PhDrain;
      end
      // empty payload completes here
      if (hdr_len == 32'd0) begin
        if (phase_d == PhCmd) begin
          ev = EvDone;
        end
        phase_d = PhHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      hdr_cnt_q   <= '0;
      len_q       <= '0;
      pay_cnt_q   <= '0;
      ota_prog_q  <= '0;
      rbt_prog_q  <= '0;
      ota_seen_q  <= 1'b0;
      rbt_seen_q  <= 1'b0;
      zero_seen_q <= 1'b0;
      bad_cnt_q   <= '0;
      leg_cnt_q   <= '0;
    end else if (fire) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      len_q       <= len_d;
      pay_cnt_q   <= pay_cnt_d;
      ota_prog_q  <= ota_prog_d;
      rbt_prog_q  <= rbt_prog_d;
      ota_seen_q  <= ota_seen_d;
      rbt_seen_q  <= rbt_seen_d;
      zero_seen_q <= zero_seen_d;
      bad_cnt_q   <= bad_cnt_d;
      leg_cnt_q   <= leg_cnt_d;
    end
  end

  // Header byte store
  always_ff @(posedge clk_i) begin
    if (fire && hdr_wr) begin
      hdr_store_q[hdr_cnt_q] <= c;
    end
  end

  assign result_o.event_res          = ev;
  assign result_o.ota_request        = ota_req;
  assign result_o.reboot_request     = rbt_req;
  assign result_o.bad_magic_total    = bad_cnt_d;
  assign result_o.legacy_frame_total = leg_cnt_d;

endmodule

[sv/mld_out_stage.sv]
module mld_out_stage import mld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    advance_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  // Result register takes a new transfer once the old one has gone
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && item_valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[sv/magic_length_deframer_top.sv]
// Flow: a transfer accepted into the input register is parsed and loaded
// into the result register once that register is free, then offered there.
// Throughput: one byte or restart event per cycle, set by the single-pass
// parser between the two registers, while out_stall_i does not hold the output.
// Reset (rst_ni, asynchronous, active low): header hunt, counters cleared.
module magic_length_deframer_top import mld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic        ota_request_o,
  output logic        reboot_request_o,
  output logic [31:0] bad_magic_total_o,
  output logic [31:0] legacy_frame_total_o
);

  logic    advance;
  logic    item_valid;
  item_t   item;
  result_t res_next;
  result_t res_out;

  mld_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mld_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_i    (advance),
    .result_o     (res_next)
  );

  mld_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .result_i     (res_next),
    .out_stall_i  (out_stall_i),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .result_o     (res_out)
  );

  assign event_res_o          = res_out.event_res;
  assign ota_request_o        = res_out.ota_request;
  assign reboot_request_o     = res_out.reboot_request;
  assign bad_magic_total_o    = res_out.bad_magic_total;
  assign legacy_frame_total_o = res_out.legacy_frame_total;

endmodule

[tb/sv/mld_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the deframer, keeps its own model of the parser
// and compares every result transfer with the oldest prediction.
module mld_checker import mld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  event_res_i,
  input  logic        ota_request_i,
  input  logic        reboot_request_i,
  input  logic [31:0] bad_magic_total_i,
  input  logic [31:0] legacy_frame_total_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {
    ScanHunt    = 2'd0,
    ScanCommand = 2'd1,
    ScanDrain   = 2'd2
  } scan_e;

  localparam int unsigned ReportCap = 30;
  localparam logic [3:0]  OtaLen    = 4'd5;
  localparam logic [3:0]  RebootLen = 4'd8;
  localparam logic [7:0]  QuoteChar = 8'h22;
  localparam logic [31:0] LegacyId  = 32'hAABB_CCDD;
  localparam logic [31:0] CommandId = 32'hAABB_CCEE;

  // Quoted words, padded to a common depth
  localparam logic [7:0] OtaText    [8] = '{8'h22, 8'h6F, 8'h74, 8'h61,
                                            8'h22, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] RebootText [8] = '{8'h22, 8'h72, 8'h65, 8'h62,
                                            8'h6F, 8'h6F, 8'h74, 8'h22};

  // Model state
  scan_e       scan;
  logic [2:0]  hdr_cnt;
  logic [7:0]  hdr [7];
  logic [31:0] frame_len;
  logic [31:0] frame_pos;
  logic [3:0]  ota_prog;
  logic [3:0]  reboot_prog;
  logic        ota_hit;
  logic        reboot_hit;
  logic        nul_hit;
  logic [31:0] bad_total;
  logic [31:0] legacy_total;

  result_t     results_due [$];
  int unsigned fails;

  function automatic void back_to_hunt();
    scan      = ScanHunt;
    hdr_cnt   = 3'd0;
    frame_pos = 32'd0;
  endfunction

  // Next progress of a quoted-word matcher; a quote restarts at one
  function automatic logic [3:0] word_step(input bit reboot, input logic [3:0] prog,
                                           input logic [7:0] c);
    logic [3:0] wlen;
    logic [7:0] want;
    wlen = reboot ? RebootLen : OtaLen;
    want = reboot ? RebootText[prog[2:0]] : OtaText[prog[2:0]];
    if (prog < wlen && want == c) return prog + 4'd1;
    return (c == QuoteChar) ? 4'd1 : 4'd0;
  endfunction

  // Advance the model by one accepted stream transfer
  function automatic result_t parse_byte(input logic kind, input logic [7:0] c);
    result_t r;
    logic [31:0] magic;
    r = '0;
    r.event_res = EvNone;
    if (kind) begin
      back_to_hunt();
    end else if (scan == ScanCommand || scan == ScanDrain) begin
      frame_pos = frame_pos + 32'd1;
      if (scan == ScanCommand && !nul_hit) begin
        if (c == 8'h00) begin
          nul_hit = 1'b1;
        end else begin
          if (!ota_hit) begin
            ota_prog = word_step(1'b0, ota_prog, c);
            if (ota_prog >= OtaLen) begin
              ota_hit  = 1'b1;
              ota_prog = 4'd0;
            end
          end
          if (!reboot_hit) begin
            reboot_prog = word_step(1'b1, reboot_prog, c);
            if (reboot_prog >= RebootLen) begin
              reboot_hit  = 1'b1;
              reboot_prog = 4'd0;
            end
          end
        end
      end
      if (frame_pos >= frame_len) begin
        if (scan == ScanCommand) begin
          r.event_res      = EvDone;
          r.ota_request    = ota_hit;
          r.reboot_request = reboot_hit && !ota_hit;
        end else begin
          r.event_res = EvDrained;
        end
        back_to_hunt();
      end
    end else if (hdr_cnt < 3'd7) begin
      hdr[hdr_cnt] = c;
      hdr_cnt      = hdr_cnt + 3'd1;
    end else begin
      // Last header byte: decode magic and little-endian length
      frame_len = {c, hdr[6], hdr[5], hdr[4]};
      magic     = {hdr[0], hdr[1], hdr[2], hdr[3]};
      hdr_cnt   = 3'd0;
      frame_pos = 32'd0;
      if (magic == LegacyId) begin
        legacy_total = legacy_total + 32'd1;
        r.event_res  = EvLegacy;
        scan         = ScanDrain;
      end else if (magic == CommandId) begin
        if (frame_len <= MaxPayload) begin
          r.event_res = EvStart;
          scan        = ScanCommand;
          ota_prog    = 4'd0;
          reboot_prog = 4'd0;
          ota_hit     = 1'b0;
          reboot_hit  = 1'b0;
          nul_hit     = 1'b0;
        end else begin
          r.event_res = EvOversize;
          scan        = ScanDrain;
        end
      end else begin
        bad_total   = bad_total + 32'd1;
        r.event_res = EvBadMagic;
        scan        = ScanDrain;
      end
      // Empty payload finishes on the header itself
      if (frame_len == 32'd0) begin
        if (scan == ScanCommand) r.event_res = EvDone;
        back_to_hunt();
      end
    end
    r.bad_magic_total    = bad_total;
    r.legacy_frame_total = legacy_total;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
    if (got !== want) begin
      bad = 1'b1;
      if (fails < ReportCap) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  // Sample both channels at each edge; results are retired before new
  // predictions go in, so a result never matches its own input transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    bit      bad;
    if (!rst_ni) begin
      back_to_hunt();
      for (int i = 0; i < 7; i++) hdr[i] = 8'h00;
      frame_len    = 32'd0;
      ota_prog     = 4'd0;
      reboot_prog  = 4'd0;
      ota_hit      = 1'b0;
      reboot_hit   = 1'b0;
      nul_hit      = 1'b0;
      bad_total    = 32'd0;
      legacy_total = 32'd0;
      results_due.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          if (fails < ReportCap) begin
            $display("%0t: result transfer with nothing expected, event %0d",
                     $time, event_res_i);
          end
          fails++;
        end else begin
          want = results_due.pop_front();
          bad  = 1'b0;
          compare_field("event_res", 32'(want.event_res), 32'(event_res_i), bad);
          compare_field("ota_request", 32'(want.ota_request), 32'(ota_request_i), bad);
          compare_field("reboot_request", 32'(want.reboot_request),
                        32'(reboot_request_i), bad);
          compare_field("bad_magic_total", want.bad_magic_total, bad_magic_total_i, bad);
          compare_field("legacy_frame_total", want.legacy_frame_total,
                        legacy_frame_total_i, bad);
          if (bad) fails++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(parse_byte(kind_i, data_byte_i));
      end
      fail_count_o <= fails;
      pending_o    <= results_due.size();
    end
  end

endmodule

[tb/sv/tb_magic_length_deframer_top.sv]
`timescale 1ns / 100ps

module tb_magic_length_deframer_top;
  import mld_pkg::*;

  localparam int unsigned StreamItems = 1000;
  localparam int unsigned CalmFrom    = 880;  // no idling after this many
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned PauseAt     = 600;
  localparam int unsigned QuietLimit  = 500;
  localparam int unsigned DrainWait   = 4;

  localparam logic [31:0] CmdHdr    = {CmdMagic[0], CmdMagic[1], CmdMagic[2], CmdMagic[3]};
  localparam logic [31:0] LegacyHdr = {LegacyMagic[0], LegacyMagic[1],
                                       LegacyMagic[2], LegacyMagic[3]};

  // Characters that feed the word matchers
  localparam logic [7:0] WordChars [7] = '{8'h22, 8'h6F, 8'h74, 8'h61,
                                           8'h72, 8'h65, 8'h62};

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        kind        = 1'b0;
  logic [7:0]  data_byte   = 8'h00;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  event_res;
  logic        ota_request;
  logic        reboot_request;
  logic [31:0] bad_magic_total;
  logic [31:0] legacy_frame_total;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent      = 0;
  bit          idle_en   = 1'b0;
  logic        hold_go   = 1'b0;

  always #5 clk = ~clk;

  magic_length_deframer_top u_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .kind_i               (kind),
    .data_byte_i          (data_byte),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .event_res_o          (event_res),
    .ota_request_o        (ota_request),
    .reboot_request_o     (reboot_request),
    .bad_magic_total_o    (bad_magic_total),
    .legacy_frame_total_o (legacy_frame_total)
  );

  mld_checker u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .kind_i               (kind),
    .data_byte_i          (data_byte),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .event_res_i          (event_res),
    .ota_request_i        (ota_request),
    .reboot_request_i     (reboot_request),
    .bad_magic_total_i    (bad_magic_total),
    .legacy_frame_total_i (legacy_frame_total),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // One stream transfer, with an optional gap before it
  task automatic put_item(input logic k, input logic [7:0] b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Header plus payload; keep >= 0 cuts the frame after that many bytes
  // and follows it with a link restart
  task automatic put_frame(input logic [31:0] magic, input logic [31:0] len,
                           input int keep, input bit wordy);
    logic [7:0]      seq [$];
    longint unsigned n;
    int unsigned     r;
    int unsigned     pos;
    int unsigned     pick;
    seq = '{magic[31:24], magic[23:16], magic[15:8], magic[7:0],
            len[7:0], len[15:8], len[23:16], len[31:24]};
    n = len;
    if (keep >= 0 && n > longint'(keep)) n = keep;
    for (longint unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 31);
      if (!wordy) seq.push_back(8'($urandom()));
      else if (r == 0) seq.push_back(8'h00);
      else if (r < 16) seq.push_back(WordChars[r % 7]);
      else seq.push_back(8'($urandom_range(1, 255)));
    end
    // Drop whole quoted words into wordy payloads
    if (wordy && $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 2);
      if (pick != 1 && n >= 5) begin
        pos = 8 + $urandom_range(0, int'(n) - 5);
        for (int j = 0; j < 5; j++) seq[pos + j] = OtaWord[j];
      end
      if (pick != 0 && n >= 8) begin
        pos = 8 + $urandom_range(0, int'(n) - 8);
        for (int j = 0; j < 8; j++) seq[pos + j] = RebootWord[j];
      end
    end
    for (int i = 0; i < seq.size(); i++) begin
      if (keep >= 0 && i >= keep) break;
      put_item(1'b0, seq[i]);
    end
    if (keep >= 0) put_item(1'b1, 8'($urandom()));
  endtask

  // Sender idles until the block has handed over everything it owes
  task automatic wait_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   <= 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_magic_length_deframer_top failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned idx;
    int          keep;
    logic [31:0] len;
    logic [31:0] magic;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty command, all-zero header, all-ones oversize length
    // cut short, restart in the middle of a header
    idle_en = 1'b1;
    put_frame(CmdHdr, 32'd0, -1, 1'b0);
    put_frame(32'h0000_0000, 32'd0, -1, 1'b0);
    put_frame(CmdHdr, 32'hFFFF_FFFF, 10, 1'b0);
    put_frame(LegacyHdr, 32'd1, 3, 1'b0);

    // Random frames, mostly well formed
    while (sent < StreamItems) begin
      idle_en = (sent < CalmFrom) && ($urandom_range(0, 3) != 0);
      if (!held && sent >= HoldAt) begin
        held     = 1'b1;
        hold_go <= 1'b1;
      end
      if (!paused && sent >= PauseAt) begin
        paused = 1'b1;
        wait_settled();
      end
      keep = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 20)) : -1;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        idx = $urandom_range(0, 19);
        if (idx == 0) len = 32'd0;
        else if (idx == 1) len = MaxPayload;
        else if (idx == 2) len = $urandom_range(1, MaxPayload);
        else len = $urandom_range(1, 24);
        put_frame(CmdHdr, len, keep, 1'b1);
      end else if (r < 70) begin
        len = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
        put_frame(LegacyHdr, len, keep, 1'b1);
      end else if (r < 80) begin
        magic = CmdHdr;
        if ($urandom_range(0, 1) == 1) begin
          magic = $urandom();
        end else begin
          idx = $urandom_range(0, 3);
          magic[8 * idx +: 8] = magic[8 * idx +: 8] ^ 8'($urandom_range(1, 255));
        end
        if (magic == CmdHdr || magic == LegacyHdr) magic[7:0] = 8'h00;
        len = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
        put_frame(magic, len, keep, 1'b1);
      end else if (r < 88) begin
        // Oversize: just past the limit in full, or huge and cut short
        if ($urandom_range(0, 2) == 0) begin
          put_frame(CmdHdr, MaxPayload + $urandom_range(1, 4), keep, 1'b1);
        end else begin
          len = $urandom() | 32'h0001_0000;
          put_frame(CmdHdr, len, $urandom_range(8, 20), 1'b1);
        end
      end else if (r < 94) begin
        // Long drain with a full 32-bit length, ended by a restart
        magic = ($urandom_range(0, 1) == 1) ? LegacyHdr : 32'h1234_5678;
        put_frame(magic, $urandom(), $urandom_range(8, 24), 1'b1);
      end else begin
        // Line noise, then resync
        repeat ($urandom_range(0, 12)) put_item(1'b0, 8'($urandom()));
        put_item(1'b1, 8'($urandom()));
      end
    end

    idle_en = 1'b0;
    wait_settled();
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_magic_length_deframer_top passed");
    end else begin
      $display("tb_magic_length_deframer_top failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/mld_pkg.sv
sv/mld_in_stage.sv
sv/mld_parser.sv
sv/mld_out_stage.sv
sv/magic_length_deframer_top.sv
tb/sv/mld_checker.sv
tb/sv/tb_magic_length_deframer_top.sv
